// ===== hw/rtl/bju_pkg.sv =====
package bju_pkg;

  localparam int unsigned PC_W        = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned CYC_W       = 3;

  localparam logic [PC_W-1:0] PAGE_MASK = 16'hff00;
  localparam logic [PC_W-1:0] LOW_MASK  = 16'h00ff;

  // instruction cost in cycles
  localparam logic [CYC_W-1:0] CYC_SHORT  = 3'd2;
  localparam logic [CYC_W-1:0] CYC_TAKEN  = 3'd3;
  localparam logic [CYC_W-1:0] CYC_CROSS  = 3'd4;
  localparam logic [CYC_W-1:0] CYC_JMP    = 3'd3;
  localparam logic [CYC_W-1:0] CYC_STACK  = 3'd6;

  typedef enum logic [2:0] {
    OP_BPL = 3'd0,
    OP_BMI = 3'd1,
    OP_BVC = 3'd2,
    OP_JMP = 3'd3,
    OP_JSR = 3'd4,
    OP_RTI = 3'd5,
    OP_RTS = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PC_W-1:0]  pc;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] sp;
    logic             nf;
    logic             vf;
  } item_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic [BYTE_W-1:0] next_sp;
    logic [BYTE_W-1:0] status;
    logic [CYC_W-1:0]  cycles;
  } result_t;

endpackage

// ===== hw/rtl/bju_ram.sv =====
module bju_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bju_calc.sv =====
module bju_calc (
  input  bju_pkg::item_t               item,
  input  logic [bju_pkg::BYTE_W-1:0]   pop_status,
  input  logic [bju_pkg::BYTE_W-1:0]   pop_lo,
  input  logic [bju_pkg::BYTE_W-1:0]   pop_hi,
  output bju_pkg::result_t             res
);
  import bju_pkg::*;

  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] disp;
  logic [PC_W-1:0] target;
  logic [PC_W-1:0] abs_target;
  logic [PC_W-1:0] popped;
  logic            taken;
  logic            page_cross;

  always_comb begin
    pc_next    = item.pc + 16'd2;
    disp       = {{BYTE_W{item.lo[BYTE_W-1]}}, item.lo};
    target     = pc_next + disp;
    page_cross = (target & PAGE_MASK) != (pc_next & PAGE_MASK);
    abs_target = {item.hi, item.lo};
    popped     = {pop_hi, pop_lo} & (PAGE_MASK | LOW_MASK);

    taken = 1'b0;
    unique case (item.op)
      OP_BPL:  taken = !item.nf;
      OP_BMI:  taken = item.nf;
      OP_BVC:  taken = !item.vf;
      default: taken = 1'b0;
    endcase

    res.next_pc = item.pc;
    res.next_sp = item.sp;
    res.status  = '0;
    res.cycles  = CYC_SHORT;
    unique case (item.op)
      OP_BPL, OP_BMI, OP_BVC: begin
        res.next_pc = taken ? target : pc_next;
        res.cycles  = !taken ? CYC_SHORT : (page_cross ? CYC_CROSS : CYC_TAKEN);
      end
      OP_JMP: begin
        res.next_pc = abs_target;
        res.cycles  = CYC_JMP;
      end
      OP_JSR: begin
        res.next_pc = abs_target;
        res.next_sp = item.sp - 8'd2;
        res.cycles  = CYC_STACK;
      end
      OP_RTI: begin
        res.next_pc = popped;
        res.next_sp = item.sp + 8'd3;
        res.status  = pop_status;
        res.cycles  = CYC_STACK;
      end
      OP_RTS: begin
        res.next_pc = popped + 16'd1;
        res.next_sp = item.sp + 8'd2;
        res.cycles  = CYC_STACK;
      end
      default: begin
        res.next_pc = item.pc;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cpu6502_branch_jump_unit.sv =====
// branches, jmp and unused codes finish without stack access; jsr pushes two bytes,
// rts pops two and rti pops three, one stack ram access per cycle; a full output
// register stalls the finish; a new item is taken as the last one finishes, and the
// output register lets the next item start while a result waits
// reset clears the control state only; stack contents are undefined until pushed
module cpu6502_branch_jump_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_current_pc,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic [7:0]  in_stack_pointer,
  input  logic        in_negative_flag,
  input  logic        in_overflow_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_pc,
  output logic [7:0]  out_next_stack_pointer,
  output logic [7:0]  out_restored_status,
  output logic [2:0]  out_cycle_count
);
  import bju_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  // item under execution and its access step
  item_t             item_r;
  logic              busy_r;
  logic [1:0]        step_r;
  logic [1:0]        step_nxt;
  // bytes popped so far
  logic [BYTE_W-1:0] stat_r;
  logic [BYTE_W-1:0] plo_r;

  // output register
  result_t           out_r;
  logic              out_valid_r;

  logic              last_step;
  logic              is_pop;
  logic              finish;
  logic              accept;
  logic [1:0]        rd_idx;
  logic [PC_W-1:0]   ret_pc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  result_t           calc_res;
  logic [BYTE_W-1:0] pop_hi;

  // last access step of each op; non-stack ops are on their last step from the start
  always_comb begin
    unique case (item_r.op)
      OP_JSR:  last_step = (step_r == 2'd1);
      OP_RTS:  last_step = (step_r == 2'd2);
      OP_RTI:  last_step = (step_r == 2'd3);
      default: last_step = 1'b1;
    endcase
    is_pop = (item_r.op == OP_RTS) || (item_r.op == OP_RTI);
  end

  assign finish   = busy_r && last_step && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r || finish;
  assign step_nxt = step_r + 2'd1;

  // push: write at sp, then sp-1, high byte first
  assign ret_pc    = item_r.pc + 16'd2;
  assign ram_we    = busy_r && (item_r.op == OP_JSR);
  assign ram_waddr = item_r.sp - {6'd0, step_r};
  assign ram_wdata = (step_r == 2'd0) ? ret_pc[PC_W-1:BYTE_W] : ret_pc[BYTE_W-1:0];

  // pop: read sp+1 upward (to sp+2 for rts, sp+3 for rti); on the final step the last
  // read is reissued so the registered read data holds while the output side stalls
  assign rd_idx    = (is_pop && last_step) ? (step_r - 2'd1) : step_r;
  assign ram_raddr = item_r.sp + 8'd1 + {6'd0, rd_idx};

  bju_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // last popped byte comes straight from the ram read register
  assign pop_hi = ram_rdata;

  bju_calc u_calc (
    .item       (item_r),
    .pop_status (stat_r),
    .pop_lo     ((item_r.op == OP_RTI || item_r.op == OP_RTS) ? plo_r : 8'd0),
    .pop_hi     (pop_hi),
    .res        (calc_res)
  );

  // sequencer: load a beat, step through the stack accesses, hand off the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (busy_r && !last_step) begin
        step_r <= step_nxt;
      end
    end
  end

  // payload of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op <= op_t'(in_op);
      item_r.pc <= in_current_pc;
      item_r.lo <= in_operand_low;
      item_r.hi <= in_operand_high;
      item_r.sp <= in_stack_pointer;
      item_r.nf <= in_negative_flag;
      item_r.vf <= in_overflow_flag;
    end
    // capture popped bytes as the read data arrives
    if (busy_r && !last_step) begin
      if (item_r.op == OP_RTI) begin
        if (step_r == 2'd1) begin
          stat_r <= ram_rdata;
        end
        if (step_r == 2'd2) begin
          plo_r <= ram_rdata;
        end
      end else if (item_r.op == OP_RTS) begin
        if (step_r == 2'd1) begin
          plo_r <= ram_rdata;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= calc_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_next_pc            = out_r.next_pc;
  assign out_next_stack_pointer = out_r.next_sp;
  assign out_restored_status    = out_r.status;
  assign out_cycle_count        = out_r.cycles;

endmodule
